// ===== hdl/gvs_pkg.sv =====
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared types and constants of the genotypic value scorer: table geometry,
// field widths, genotype and function codes, register map.
// ----------------------------------------------------------------------------
package gvs_pkg;

    // table geometry
    localparam int NUM_LOCI = 4096;
    localparam int LOCUS_W  = $clog2(NUM_LOCI);

    // field widths
    localparam int EFF_W   = 32;
    localparam int SUM_W   = 48;
    localparam int DELTA_W = EFF_W + 1;

    // config port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_EFFECT_MODE  = 2'd0;
    localparam logic [1:0] REG_MEAN_VALUE   = 2'd1;
    localparam logic [1:0] REG_UNIFORM_ADD  = 2'd2;
    localparam logic [1:0] REG_UNIFORM_DOM  = 2'd3;

    // function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SCORE = 1'b1;

    // genotype codes
    localparam logic [1:0] GENO_HOM_REC  = 2'd0;
    localparam logic [1:0] GENO_HET      = 2'd1;
    localparam logic [1:0] GENO_HOM_DOM  = 2'd2;
    localparam logic [1:0] GENO_MISSING  = 2'd3;

    // one table entry
    typedef struct packed {
        logic                    in_trait;
        logic signed [EFF_W-1:0] add_eff;
        logic signed [EFF_W-1:0] dom_eff;
    } t_entry;

    // load request toward the table
    typedef struct packed {
        logic               en;
        logic [LOCUS_W-1:0] addr;
        t_entry             entry;
    } t_tbl_wr;

endpackage

// ===== hdl/gvs_table.sv =====
// ----------------------------------------------------------------------------
// gvs_table
// Per-locus effect table: one synchronous memory holding trait membership,
// additive and dominance effects. Clears itself after reset, one entry a cycle.
// ----------------------------------------------------------------------------
module gvs_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gvs_pkg::t_tbl_wr             i_wr,
    input  logic                         i_rd_en,
    input  logic [gvs_pkg::LOCUS_W-1:0]  i_rd_addr,
    output gvs_pkg::t_entry              o_rd_data,
    output logic                         o_busy
);

    gvs_pkg::t_entry              mem [gvs_pkg::NUM_LOCI];
    gvs_pkg::t_entry              r_rd_data;
    logic                         r_clr_busy;
    logic [gvs_pkg::LOCUS_W-1:0]  r_clr_addr;
    logic                         wr_en;
    logic [gvs_pkg::LOCUS_W-1:0]  wr_addr;
    gvs_pkg::t_entry              wr_data;

    // clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == gvs_pkg::LOCUS_W'(gvs_pkg::NUM_LOCI - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port: sweep wins, loads are ignored while it runs
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr.en;
            wr_addr = i_wr.addr;
            wr_data = i_wr.entry;
        end
    end

    // memory array
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ===== hdl/genotypic_value_scorer_top.sv =====
// ----------------------------------------------------------------------------
// genotypic_value_scorer_top
// Walks a specimen's loci, adding additive / dominance effects from a
// per-locus table or from uniform registers, and emits a saturated sum.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   func locus genotype in_trait
//                                                 add_effect dom_effect last
//  out       output     o_out_valid / i_out_stall value overflow
//  config    input      APB write/read            effect_mode mean uniform_*
//
// One item per cycle while o_in_stall is low. A score item reads the table at
// the accept edge and is accumulated in the next cycle unless stage 1 is held;
// a last item loads the output register as it accumulates. The 48-bit sum add
// and clamp sets the cycle time. Input stalls while the reset clear sweep runs.
// An unread result stalls only when a further last item reaches the adder.
// ----------------------------------------------------------------------------
module genotypic_value_scorer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gvs_pkg::PADDR_W-1:0]         paddr,
    input  logic [gvs_pkg::PDATA_W-1:0]         pwdata,
    output logic [gvs_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [gvs_pkg::LOCUS_W-1:0]         i_locus,
    input  logic [1:0]                          i_genotype,
    input  logic                                i_in_trait,
    input  logic signed [gvs_pkg::EFF_W-1:0]    i_add_effect,
    input  logic signed [gvs_pkg::EFF_W-1:0]    i_dom_effect,
    input  logic                                i_last,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gvs_pkg::SUM_W-1:0]    o_value,
    output logic                                o_overflow
);

    // config registers
    logic                              r_effect_mode;
    logic signed [gvs_pkg::EFF_W-1:0]  r_mean_value;
    logic signed [gvs_pkg::EFF_W-1:0]  r_uniform_add;
    logic signed [gvs_pkg::EFF_W-1:0]  r_uniform_dom;
    logic                              cfg_wr;

    // stage 1 (score item with its table entry)
    logic                              r_s1_valid;
    logic [1:0]                        r_s1_geno;
    logic                              r_s1_last;
    logic                              n_s1_valid;

    // specimen state
    logic signed [gvs_pkg::SUM_W-1:0]  r_sum;
    logic                              r_sat;
    logic                              r_open;
    logic signed [gvs_pkg::SUM_W-1:0]  n_sum;
    logic                              n_sat;

    // output register
    logic                              r_out_valid;
    logic signed [gvs_pkg::SUM_W-1:0]  r_out_value;
    logic                              r_out_ovf;

    // table interface
    gvs_pkg::t_tbl_wr                  tbl_wr;
    gvs_pkg::t_entry                   tbl_rd;
    logic                              tbl_busy;

    logic                              in_accept;
    logic                              s1_hold;
    logic                              s1_fire;
    logic signed [gvs_pkg::EFF_W-1:0]  eff_add;
    logic signed [gvs_pkg::EFF_W-1:0]  eff_dom;
    logic signed [gvs_pkg::DELTA_W-1:0] delta;
    logic                              delta_en;
    logic signed [gvs_pkg::SUM_W-1:0]  base_sum;
    logic                              base_sat;
    logic signed [gvs_pkg::SUM_W:0]    wide_sum;

    // config write / read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode <= 1'b0;
            r_mean_value  <= '0;
            r_uniform_add <= '0;
            r_uniform_dom <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                gvs_pkg::REG_EFFECT_MODE: r_effect_mode <= pwdata[0];
                gvs_pkg::REG_MEAN_VALUE:  r_mean_value  <= pwdata;
                gvs_pkg::REG_UNIFORM_ADD: r_uniform_add <= pwdata;
                gvs_pkg::REG_UNIFORM_DOM: r_uniform_dom <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gvs_pkg::REG_EFFECT_MODE: prdata = {{(gvs_pkg::PDATA_W-1){1'b0}}, r_effect_mode};
            gvs_pkg::REG_MEAN_VALUE:  prdata = r_mean_value;
            gvs_pkg::REG_UNIFORM_ADD: prdata = r_uniform_add;
            gvs_pkg::REG_UNIFORM_DOM: prdata = r_uniform_dom;
            default:                  prdata = '0;
        endcase
    end

    // input handshake
    assign s1_hold    = r_s1_valid && r_s1_last && r_out_valid && i_out_stall;
    assign s1_fire    = r_s1_valid && !s1_hold;
    assign o_in_stall = tbl_busy || s1_hold;
    assign in_accept  = i_in_valid && !o_in_stall;

    // table load / lookup
    assign tbl_wr.en             = in_accept && (i_func == gvs_pkg::FUNC_LOAD);
    assign tbl_wr.addr           = i_locus;
    assign tbl_wr.entry.in_trait = i_in_trait;
    assign tbl_wr.entry.add_eff  = i_add_effect;
    assign tbl_wr.entry.dom_eff  = i_dom_effect;

    gvs_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (in_accept && (i_func == gvs_pkg::FUNC_SCORE)),
        .i_rd_addr (i_locus),
        .o_rd_data (tbl_rd),
        .o_busy    (tbl_busy)
    );

    // stage 1 control
    assign n_s1_valid = s1_hold ? r_s1_valid : (in_accept && (i_func == gvs_pkg::FUNC_SCORE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_func == gvs_pkg::FUNC_SCORE)) begin
            r_s1_geno <= i_genotype;
            r_s1_last <= i_last;
        end
    end

    // effect select and signed delta
    assign eff_add = r_effect_mode ? r_uniform_add : tbl_rd.add_eff;
    assign eff_dom = r_effect_mode ? r_uniform_dom : tbl_rd.dom_eff;

    always_comb begin
        delta_en = tbl_rd.in_trait;
        unique case (r_s1_geno)
            gvs_pkg::GENO_HOM_DOM: delta = gvs_pkg::DELTA_W'(eff_add);
            gvs_pkg::GENO_HOM_REC: delta = -gvs_pkg::DELTA_W'(eff_add);
            gvs_pkg::GENO_HET:     delta = gvs_pkg::DELTA_W'(eff_dom);
            default: begin
                delta    = '0;
                delta_en = 1'b0;
            end
        endcase
    end

    // accumulate with clamp to 48 bits
    assign base_sum = r_open ? r_sum : gvs_pkg::SUM_W'(r_mean_value);
    assign base_sat = r_open ? r_sat : 1'b0;
    assign wide_sum = (gvs_pkg::SUM_W+1)'(base_sum) + (gvs_pkg::SUM_W+1)'(delta);

    always_comb begin
        n_sum = base_sum;
        n_sat = base_sat;
        if (delta_en) begin
            if (wide_sum[gvs_pkg::SUM_W] != wide_sum[gvs_pkg::SUM_W-1]) begin
                n_sat = 1'b1;
                n_sum = wide_sum[gvs_pkg::SUM_W] ? {1'b1, {(gvs_pkg::SUM_W-1){1'b0}}}
                                                 : {1'b0, {(gvs_pkg::SUM_W-1){1'b1}}};
            end else begin
                n_sum = wide_sum[gvs_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_sat  <= 1'b0;
            r_open <= 1'b0;
        end else if (s1_fire) begin
            r_sum  <= n_sum;
            r_sat  <= n_sat;
            r_open <= !r_s1_last;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_value <= n_sum;
            r_out_ovf   <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_overflow  = r_out_ovf;

    // checks
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result word without a last locus");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value)))
        else $error("pending result word overwritten");

    a_close_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> !r_open)
        else $error("specimen still open after last locus");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> !in_accept)
        else $error("item accepted during table clear");

endmodule
